FILE: rtl/ptt_pkg.sv
// package for the page table trainer with guarded replacement
// shared widths, register indexes and the controller/datapath command and status structs
// no dependencies
package ptt_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int PAGE_W = 36;
  localparam int ID_W = 16;
  localparam int TICK_W = 48;
  localparam int ADDR_W = 48;
  localparam int TRAIN_W = 8;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_DEFENSE   = 2'd1,
    REG_GLOBAL    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic capture;   // latch the input item, run compares
    logic update;    // apply hit or miss update, load result
  } ptt_cmd_t;

  typedef struct packed {
    logic busy;
  } ptt_sts_t;
endpackage

FILE: rtl/ptt_ctrl.sv
// controller state machine for the page table trainer
// depends on ptt_pkg
module ptt_ctrl import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output ptt_cmd_t cmd,
  output logic     busy
);
  typedef enum logic [0:0] {S_IDLE, S_UPD} state_t;
  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) state_r <= S_UPD;
        S_UPD:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.update  = (state_r == S_UPD);
  assign busy        = (state_r == S_UPD);
endmodule

FILE: rtl/ptt_dp.sv
// datapath: entry table, compare and oldest search, shift removal, result register
// depends on ptt_pkg
module ptt_dp import ptt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ptt_cmd_t            cmd,
  input  logic [ADDR_W-1:0]   in_access_addr,
  input  logic [ID_W-1:0]     in_context_asid,
  input  logic [ID_W-1:0]     in_requester_core,
  input  logic [TICK_W-1:0]   in_now_tick,
  input  logic [7:0]          in_rand_byte,
  input  logic [TRAIN_W-1:0]  thr,
  input  logic                def_en,
  input  logic                glo_mode,
  output logic                done,
  output logic                page_present,
  output logic                optimized_hit,
  output logic [ID_W-1:0]     owner_asid,
  output logic                now_enabled,
  output logic                evicted,
  output logic [PAGE_W-1:0]   evicted_page,
  output logic                guard_triggered
);
  logic [PAGE_W-1:0]  pg_r   [ENTRIES];
  logic [ID_W-1:0]    as_r   [ENTRIES];
  logic [ID_W-1:0]    co_r   [ENTRIES];
  logic [TRAIN_W-1:0] tc_r   [ENTRIES];
  logic [TICK_W-1:0]  lu_r   [ENTRIES];
  logic               en_r   [ENTRIES];
  logic [CNT_W-1:0]   cnt_r;

  // captured item and search results from the capture step
  logic [PAGE_W-1:0] q_page_r;
  logic [ID_W-1:0]   q_asid_r, q_core_r;
  logic [TICK_W-1:0] q_tick_r;
  logic [7:0]        q_rand_r;
  logic [ENTRIES-1:0] hitv_r, sidv_r, ocv_r;

  logic [ENTRIES-1:0] hitv, sidv, ocv, valid;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i] = (CNT_W'(i) < cnt_r);
      hitv[i] = valid[i] && pg_r[i] == in_access_addr[ADDR_W-1:12];
      sidv[i] = valid[i] && as_r[i] == in_context_asid && co_r[i] == in_requester_core;
      ocv[i]  = valid[i] && as_r[i] == in_context_asid && co_r[i] != in_requester_core;
    end
  end

  // oldest among a mask, earliest wins ties
  // balanced compare tree, the lower-index side is kept on equal ticks
  function automatic logic [IDX_W:0] oldest(input logic [ENTRIES-1:0] m,
                                            input logic [TICK_W-1:0] lu [ENTRIES]);
    logic              v  [ENTRIES];
    logic [IDX_W-1:0]  ix [ENTRIES];
    logic [TICK_W-1:0] t  [ENTRIES];
    for (int i = 0; i < ENTRIES; i++) begin
      v[i] = m[i];
      ix[i] = IDX_W'(i);
      t[i] = lu[i];
    end
    for (int lvl = 0; lvl < IDX_W; lvl++) begin
      for (int i = 0; i < ENTRIES / 2; i++) begin
        if (i < (ENTRIES >> (lvl + 1))) begin
          if (v[2*i+1] && (!v[2*i] || t[2*i+1] < t[2*i])) begin
            v[i] = 1'b1;
            ix[i] = ix[2*i+1];
            t[i] = t[2*i+1];
          end else begin
            v[i] = v[2*i];
            ix[i] = ix[2*i];
            t[i] = t[2*i];
          end
        end
      end
    end
    return {v[0], ix[0]};
  endfunction

  logic [ENTRIES-1:0] validq;
  logic [IDX_W:0] h_lru, h_sid, h_oc, vic;
  logic [IDX_W-1:0] hidx;
  logic hit, full, fire;
  logic [8:0] pthr;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) validq[i] = (CNT_W'(i) < cnt_r);
    h_lru = oldest(validq, lu_r);
    h_sid = oldest(sidv_r, lu_r);
    h_oc  = oldest(ocv_r, lu_r);
    hit = |hitv_r;
    hidx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) if (hitv_r[i]) hidx = IDX_W'(i);
    full = (cnt_r >= CNT_W'(ENTRIES));
    pthr = 9'((32'(cnt_r) * 256) / ENTRIES);
    fire = def_en && (cnt_r != '0) && ({1'b0, q_rand_r} <= pthr);
    vic = '0;
    if (def_en) begin
      if (fire) begin
        if (glo_mode) vic = h_lru;
        else vic = h_sid[IDX_W] ? h_sid : (full ? h_lru : '0);
      end else if (full) vic = h_lru;
    end else begin
      vic = h_oc[IDX_W] ? h_oc : (full ? h_lru : '0);
    end
  end

  // slot that takes the new page after an optional removal
  logic [CNT_W-1:0] tail;
  assign tail = vic[IDX_W] ? cnt_r - 1'b1 : cnt_r;

  logic [TRAIN_W-1:0] tc_inc;
  logic en_new;
  assign tc_inc = (tc_r[hidx] == '1) ? tc_r[hidx] : tc_r[hidx] + 1'b1;
  assign en_new = en_r[hidx] || (tc_inc >= thr);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_page_r <= in_access_addr[ADDR_W-1:12];
      q_asid_r <= in_context_asid;
      q_core_r <= in_requester_core;
      q_tick_r <= in_now_tick;
      q_rand_r <= in_rand_byte;
      hitv_r <= hitv; sidv_r <= sidv; ocv_r <= ocv;
    end
    if (cmd.update) begin
      page_present <= hit;
      optimized_hit <= hit && en_r[hidx];
      owner_asid <= hit ? as_r[hidx] : '0;
      now_enabled <= hit && en_new;
      evicted <= !hit && vic[IDX_W];
      evicted_page <= (!hit && vic[IDX_W]) ? pg_r[vic[IDX_W-1:0]] : '0;
      guard_triggered <= !hit && fire;
      if (hit) begin
        lu_r[hidx] <= q_tick_r;
        if (!en_r[hidx]) begin
          tc_r[hidx] <= tc_inc;
          en_r[hidx] <= en_new;
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (CNT_W'(i) == tail) begin
            pg_r[i] <= q_page_r; as_r[i] <= q_asid_r; co_r[i] <= q_core_r;
            tc_r[i] <= '0; lu_r[i] <= q_tick_r; en_r[i] <= 1'b0;
          end else if (vic[IDX_W] && IDX_W'(i) >= vic[IDX_W-1:0] && i + 1 < ENTRIES) begin
            pg_r[i] <= pg_r[i+1]; as_r[i] <= as_r[i+1]; co_r[i] <= co_r[i+1];
            tc_r[i] <= tc_r[i+1]; lu_r[i] <= lu_r[i+1]; en_r[i] <= en_r[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update && !hit && !vic[IDX_W] && !full) cnt_r <= cnt_r + 1'b1;
    end
  end
endmodule

FILE: rtl/page_table_trainer_guarded_replace.sv
// an accepted start latches the item and its compares, then the update step registers the result and strobes out_valid
// a new start is ignored while busy; busy is high the cycle after accept (update step)
// the receiver cannot stall, each result shows for exactly one cycle
// reset (rst_n low, synchronous): table empty, threshold 32, baseline rule
// depends on ptt_pkg, ptt_ctrl, ptt_dp
module page_table_trainer_guarded_replace import ptt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ADDR_W-1:0]  in_access_addr,
  input  logic [ID_W-1:0]    in_context_asid,
  input  logic [ID_W-1:0]    in_requester_core,
  input  logic [TICK_W-1:0]  in_now_tick,
  input  logic [7:0]         in_rand_byte,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  output logic               out_page_present,
  output logic               out_optimized_hit,
  output logic [ID_W-1:0]    out_owner_asid,
  output logic               out_now_enabled,
  output logic               out_evicted,
  output logic [PAGE_W-1:0]  out_evicted_page,
  output logic               out_guard_triggered
);
  logic [7:0] thr_r;
  logic       def_r, glo_r;
  ptt_cmd_t   cmd;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 8'd32;
      def_r <= 1'b0;
      glo_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_data;
        REG_DEFENSE:   def_r <= cfg_data[0];
        REG_GLOBAL:    glo_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ptt_ctrl u_ctrl (.clk, .rst_n, .start, .cmd, .busy);

  ptt_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_access_addr, .in_context_asid, .in_requester_core, .in_now_tick, .in_rand_byte,
    .thr(thr_r), .def_en(def_r), .glo_mode(glo_r),
    .done(out_valid),
    .page_present(out_page_present), .optimized_hit(out_optimized_hit),
    .owner_asid(out_owner_asid), .now_enabled(out_now_enabled),
    .evicted(out_evicted), .evicted_page(out_evicted_page),
    .guard_triggered(out_guard_triggered)
  );
endmodule

FILE: rtl/ptt_checker.sv
// port-level checker for the page table trainer, bound to the top level
// depends on ptt_pkg and page_table_trainer_guarded_replace
module ptt_checker import ptt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic              out_page_present,
  input logic              out_optimized_hit,
  input logic              out_now_enabled,
  input logic              out_evicted,
  input logic              out_guard_triggered,
  input logic [PAGE_W-1:0] out_evicted_page
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  a_result_after: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid) else $error("missing result");
  a_opt_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_optimized_hit |-> out_page_present && out_now_enabled)
    else $error("optimized hit without present");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_page_present |-> !out_evicted && !out_guard_triggered)
    else $error("eviction on hit");
endmodule

bind page_table_trainer_guarded_replace ptt_checker u_chk (.*);
